@@ rtl/ntpc_pkg.sv @@
`timescale 1ns / 1ps

package ntpc_pkg;

  localparam int NOTE_COUNT = 60;
  localparam int IDX_W      = 6;
  localparam int TOP_W      = 13;
  localparam int DUR_W      = 16;
  localparam int DUTY_W     = 7;
  localparam int LEN_W      = 8;
  localparam int PROD_W     = DUTY_W + TOP_W;
  localparam int CNT_W      = 5;

  // Both quotients are shifted out one bit per cycle over the product width.
  localparam int DIV_STEPS  = PROD_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd100;
  localparam logic [DUTY_W-1:0] PCT_DIVISOR = 7'd100;

  localparam logic [DUR_W-1:0]  FULL_NOTE_RESET = 16'd1000;
  localparam logic [DUTY_W-1:0] DUTY_RESET      = 7'd50;

  typedef enum logic [1:0] {
    REQ_PLAY = 2'd0,
    REQ_STOP = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic {
    CFG_FULL_NOTE = 1'b0,
    CFG_DUTY      = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD,
    ST_DONE
  } state_t;

  // PWM counter top per semitone: floor(1 MHz / f) - 1, f from 131 Hz to 3951 Hz.
  function automatic logic [TOP_W-1:0] note_top(input logic [IDX_W-1:0] idx);
    logic [TOP_W-1:0] t;
    case (idx)
      6'd0:  t = 13'd7632;  6'd1:  t = 13'd7193;  6'd2:  t = 13'd6801;
      6'd3:  t = 13'd6409;  6'd4:  t = 13'd6059;  6'd5:  t = 13'd5713;
      6'd6:  t = 13'd5404;  6'd7:  t = 13'd5101;  6'd8:  t = 13'd4806;
      6'd9:  t = 13'd4544;  6'd10: t = 13'd4290;  6'd11: t = 13'd4047;
      6'd12: t = 13'd3815;  6'd13: t = 13'd3609;  6'd14: t = 13'd3400;
      6'd15: t = 13'd3214;  6'd16: t = 13'd3029;  6'd17: t = 13'd2864;
      6'd18: t = 13'd2701;  6'd19: t = 13'd2550;  6'd20: t = 13'd2408;
      6'd21: t = 13'd2271;  6'd22: t = 13'd2144;  6'd23: t = 13'd2023;
      6'd24: t = 13'd1911;  6'd25: t = 13'd1804;  6'd26: t = 13'd1702;
      6'd27: t = 13'd1606;  6'd28: t = 13'd1516;  6'd29: t = 13'd1431;
      6'd30: t = 13'd1350;  6'd31: t = 13'd1274;  6'd32: t = 13'd1202;
      6'd33: t = 13'd1135;  6'd34: t = 13'd1071;  6'd35: t = 13'd1011;
      6'd36: t = 13'd954;   6'd37: t = 13'd900;   6'd38: t = 13'd850;
      6'd39: t = 13'd802;   6'd40: t = 13'd757;   6'd41: t = 13'd714;
      6'd42: t = 13'd674;   6'd43: t = 13'd636;   6'd44: t = 13'd601;
      6'd45: t = 13'd567;   6'd46: t = 13'd535;   6'd47: t = 13'd505;
      6'd48: t = 13'd476;   6'd49: t = 13'd450;   6'd50: t = 13'd424;
      6'd51: t = 13'd400;   6'd52: t = 13'd378;   6'd53: t = 13'd356;
      6'd54: t = 13'd336;   6'd55: t = 13'd317;   6'd56: t = 13'd300;
      6'd57: t = 13'd283;   6'd58: t = 13'd267;   6'd59: t = 13'd252;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/note_tone_pwm_controller.sv @@
`timescale 1ns / 1ps

// Buzzer note player. One request word enters on the input channel
// (in_valid / in_stall) and produces exactly one status word on the output
// channel (out_valid / out_stall) showing the state after the request.
// A play word looks up the PWM top for the note, forms the compare value
// from the duty setting and loads a duration of the whole-note setting
// divided by the length divisor. Stop turns the tone off; tick counts the
// duration down.
// For a play word the request passes through a multiply state, a
// bit-serial restoring divider that forms both quotients side by side over
// the product width, a load state and the output register. Stop, tick,
// unused codes and plays past the end of the table go straight to the
// output register. The block works on one word at a time and takes the
// next word only in the cycle after the current one has been placed in the
// output register.
// While the receiver stalls, the output word holds and a finished word
// waits in place until the output register frees up.
// Reset clears the tone state and restores both configuration registers.
module note_tone_pwm_controller
  import ntpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [IDX_W-1:0]  tone_sel,
  input  logic [LEN_W-1:0]  len_div,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DUR_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              tone_on,
  output logic [TOP_W-1:0]  period_top,
  output logic [TOP_W-1:0]  compare_value,
  output logic [DUR_W-1:0]  ticks_left,
  output logic              ended_now
);

  state_t state, state_next;

  logic [DUR_W-1:0]  full_note;
  logic [DUTY_W-1:0] duty;
  logic [DUTY_W-1:0] duty_sat;

  logic [DUR_W-1:0]  remaining_ticks;
  logic              output_enabled;
  logic [TOP_W-1:0]  top_reg;
  logic [TOP_W-1:0]  compare_reg;
  logic              ended;

  logic [LEN_W-1:0]  divisor;
  logic [PROD_W-1:0] cmp_q;
  logic [DUTY_W-1:0] cmp_rem;
  logic [PROD_W-1:0] dur_q;
  logic [LEN_W-1:0]  dur_rem;
  logic [CNT_W-1:0]  bit_cnt;

  logic              in_take;
  logic              load_out;
  logic              play_ok;
  logic [DUTY_W:0]   cmp_trial;
  logic              cmp_bit;
  logic [LEN_W:0]    dur_trial;
  logic              dur_bit;

  assign duty_sat = (duty > DUTY_FULL) ? DUTY_FULL : duty;
  assign in_take  = in_valid && !in_stall;
  assign play_ok  = ({1'b0, tone_sel} < (IDX_W + 1)'(NOTE_COUNT));

  // One quotient bit per cycle for each of the two divisions.
  assign cmp_trial = {cmp_rem, cmp_q[PROD_W-1]};
  assign cmp_bit   = (cmp_trial >= {1'b0, PCT_DIVISOR});
  assign dur_trial = {dur_rem, dur_q[PROD_W-1]};
  assign dur_bit   = (dur_trial >= {1'b0, divisor});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (req_t'(req_type) == REQ_PLAY && play_ok) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    load_out = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      full_note       <= FULL_NOTE_RESET;
      duty            <= DUTY_RESET;
      remaining_ticks <= '0;
      output_enabled  <= 1'b0;
      top_reg         <= '0;
      compare_reg     <= '0;
      ended           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FULL_NOTE: full_note <= cfg_data;
          CFG_DUTY:      duty      <= cfg_data[DUTY_W-1:0];
          default:       ;
        endcase
      end

      if (in_take) begin
        ended <= 1'b0;
        case (req_t'(req_type))
          REQ_PLAY: begin
            if (play_ok) begin
              top_reg <= note_top(tone_sel);
            end
          end
          REQ_STOP: output_enabled <= 1'b0;
          REQ_TICK: begin
            if (remaining_ticks != '0) begin
              remaining_ticks <= remaining_ticks - 1'b1;
              if (remaining_ticks == DUR_W'(1)) begin
                output_enabled <= 1'b0;
                ended          <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      if (state == ST_LOAD) begin
        compare_reg     <= cmp_q[TOP_W-1:0];
        remaining_ticks <= dur_q[DUR_W-1:0];
        output_enabled  <= 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider datapath; no reset needed, the sequencer loads it before use.
  always_ff @(posedge clk) begin
    if (in_take) begin
      divisor <= (len_div == '0) ? LEN_W'(1) : len_div;
    end
    case (state)
      ST_MUL: begin
        cmp_q   <= duty_sat * top_reg;
        dur_q   <= PROD_W'(full_note);
        cmp_rem <= '0;
        dur_rem <= '0;
        bit_cnt <= CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        cmp_q   <= {cmp_q[PROD_W-2:0], cmp_bit};
        cmp_rem <= cmp_bit ? DUTY_W'(cmp_trial - {1'b0, PCT_DIVISOR})
                           : cmp_trial[DUTY_W-1:0];
        dur_q   <= {dur_q[PROD_W-2:0], dur_bit};
        dur_rem <= dur_bit ? LEN_W'(dur_trial - {1'b0, divisor})
                           : dur_trial[LEN_W-1:0];
        bit_cnt <= bit_cnt - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tone_on       <= output_enabled;
      period_top    <= top_reg;
      compare_value <= compare_reg;
      ticks_left    <= remaining_ticks;
      ended_now     <= ended;
    end
  end

endmodule
